// ----- design/jc_pkg.sv -----
// ----------------------------------------------------------------------------
// jc_pkg: shared constants and types of the joystick conditioner
// Widths, register indexes, stick and button codes, and the controller
// command bundle.
// ----------------------------------------------------------------------------
package jc_pkg;

	localparam int SAMPLE_W = 10;
	localparam int POS_W    = 8;
	localparam int STICK_W  = 4;
	localparam int BUTTON_W = 2;
	localparam int INDEX_W  = 3;

	// Offset times 100 needs 17 bits of magnitude; the divider resolves one
	// quotient bit per step.
	localparam int DIV_W     = 17;
	localparam int DIV_STEPS = DIV_W;
	localparam int CNT_W     = 5;

	localparam int PERCENT          = 100;
	localparam int POS_MAX          = 127;
	localparam int ZERO_LIMIT       = 10;
	localparam int DOMINANCE_MARGIN = 10;
	localparam int MOVE_LIMIT       = 50;

	localparam logic [INDEX_W-1:0] REG_CENTER_X = 3'd0;
	localparam logic [INDEX_W-1:0] REG_LOW_X    = 3'd1;
	localparam logic [INDEX_W-1:0] REG_HIGH_X   = 3'd2;
	localparam logic [INDEX_W-1:0] REG_CENTER_Y = 3'd3;
	localparam logic [INDEX_W-1:0] REG_LOW_Y    = 3'd4;
	localparam logic [INDEX_W-1:0] REG_HIGH_Y   = 3'd5;
	localparam logic [INDEX_W-1:0] REG_DEAD     = 3'd6;

	localparam logic [STICK_W-1:0] STICK_ZERO     = 4'd0;
	localparam logic [STICK_W-1:0] STICK_RIGHT    = 4'd1;
	localparam logic [STICK_W-1:0] STICK_LEFT     = 4'd2;
	localparam logic [STICK_W-1:0] STICK_UP       = 4'd3;
	localparam logic [STICK_W-1:0] STICK_DOWN     = 4'd4;
	localparam logic [STICK_W-1:0] STICK_MV_RIGHT = 4'd5;
	localparam logic [STICK_W-1:0] STICK_MV_LEFT  = 4'd6;
	localparam logic [STICK_W-1:0] STICK_MV_UP    = 4'd7;
	localparam logic [STICK_W-1:0] STICK_MV_DOWN  = 4'd8;

	localparam logic [BUTTON_W-1:0] BTN_IDLE     = 2'd0;
	localparam logic [BUTTON_W-1:0] BTN_PRESSED  = 2'd1;
	localparam logic [BUTTON_W-1:0] BTN_HELD     = 2'd2;
	localparam logic [BUTTON_W-1:0] BTN_RELEASED = 2'd3;

	typedef struct packed {
		logic capture;
		logic load;
		logic step;
		logic commit;
	} jc_cmd_t;

	typedef struct packed {
		logic [DIV_W-1:0]    num_mag;
		logic [SAMPLE_W-1:0] span_mag;
		logic                neg;
		logic                zero;
	} axis_prep_t;

endpackage

// ----- design/jc_div.sv -----
// ----------------------------------------------------------------------------
// jc_div: shift-subtract divider
// Unsigned restoring division, one quotient bit per step. The quotient
// builds up in the dividend register.
// ----------------------------------------------------------------------------
module jc_div (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          load,
	input  logic                          step,
	input  logic [jc_pkg::DIV_W-1:0]      dividend,
	input  logic [jc_pkg::SAMPLE_W-1:0]   divisor,
	output logic [jc_pkg::DIV_W-1:0]      quotient
);

	logic [jc_pkg::DIV_W-1:0]    dvd_q;
	logic [jc_pkg::SAMPLE_W-1:0] dvs_q;
	logic [jc_pkg::SAMPLE_W-1:0] rem_q;
	logic [jc_pkg::SAMPLE_W:0]   trial;
	logic [jc_pkg::SAMPLE_W:0]   diff;
	logic                        ge;

	assign trial = {rem_q, dvd_q[jc_pkg::DIV_W-1]};
	assign ge    = trial >= {1'b0, dvs_q};
	assign diff  = trial - {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dvd_q <= '0;
			dvs_q <= '0;
			rem_q <= '0;
		end else if (load) begin
			dvd_q <= dividend;
			dvs_q <= divisor;
			rem_q <= '0;
		end else if (step) begin
			// Remainder stays below the divisor, so it fits in the divisor width.
			rem_q <= ge ? diff[jc_pkg::SAMPLE_W-1:0] : trial[jc_pkg::SAMPLE_W-1:0];
			dvd_q <= {dvd_q[jc_pkg::DIV_W-2:0], ge};
		end
	end

	assign quotient = dvd_q;

endmodule

// ----- design/jc_dp.sv -----
// ----------------------------------------------------------------------------
// jc_dp: joystick conditioner datapath
// Calibration registers, per-axis offset and dead zone, two serial
// dividers, saturation, and the stick and button event machines.
// ----------------------------------------------------------------------------
module jc_dp (
	input  logic                            clk,
	input  logic                            arst_n,
	input  jc_pkg::jc_cmd_t                 cmd,
	input  logic                            cfg_we,
	input  logic [jc_pkg::INDEX_W-1:0]      cfg_index,
	input  logic [jc_pkg::SAMPLE_W-1:0]     cfg_data,
	input  logic [jc_pkg::SAMPLE_W-1:0]     sample_x,
	input  logic [jc_pkg::SAMPLE_W-1:0]     sample_y,
	input  logic                            button_level,
	output logic signed [jc_pkg::POS_W-1:0] pos_x,
	output logic signed [jc_pkg::POS_W-1:0] pos_y,
	output logic [jc_pkg::STICK_W-1:0]      stick_code,
	output logic [jc_pkg::BUTTON_W-1:0]     button_code
);

	localparam int SW = jc_pkg::SAMPLE_W;
	localparam int MW = jc_pkg::POS_W - 1;

	logic [SW-1:0] center_x_q, low_x_q, high_x_q;
	logic [SW-1:0] center_y_q, low_y_q, high_y_q;
	logic [SW-1:0] dead_zone_q;

	logic [SW-1:0] smp_x_q, smp_y_q;
	logic          level_q;
	logic          neg_x_q, zero_x_q, neg_y_q, zero_y_q;

	jc_pkg::axis_prep_t prep_x, prep_y;
	logic [jc_pkg::DIV_W-1:0] quo_x, quo_y;

	logic [MW-1:0]  sat_x, sat_y;
	logic [MW:0]    ax_ext, ay_ext;
	logic           neg_x, neg_y;
	logic [jc_pkg::STICK_W-1:0]  stick_q, stick_d;
	logic [jc_pkg::BUTTON_W-1:0] button_q, button_d;
	logic signed [jc_pkg::POS_W-1:0] pos_x_q, pos_y_q;

	// Offset from center, dead zone, scaling by 100 and choice of side span.
	function automatic jc_pkg::axis_prep_t prep_axis(
		input logic [SW-1:0] smp,
		input logic [SW-1:0] ctr,
		input logic [SW-1:0] lo,
		input logic [SW-1:0] hi,
		input logic [SW-1:0] dz
	);
		jc_pkg::axis_prep_t p;
		logic signed [SW:0] off;
		logic signed [SW:0] span;
		logic [SW:0]        mag;
		logic [SW:0]        smag;
		off = $signed({1'b0, smp}) - $signed({1'b0, ctr});
		mag = off[SW] ? -off : off;
		if (mag < {1'b0, dz}) begin
			off = '0;
			mag = '0;
		end
		span = off[SW] ? $signed({1'b0, ctr}) - $signed({1'b0, lo})
		               : $signed({1'b0, hi}) - $signed({1'b0, ctr});
		smag = span[SW] ? -span : span;
		// Times 100 as 64 + 32 + 4.
		p.num_mag  = {mag, 6'b0} + {1'b0, mag, 5'b0} + {4'b0, mag, 2'b0};
		p.span_mag = smag[SW-1:0];
		p.neg      = off[SW] ^ span[SW];
		p.zero     = (span == '0);
		return p;
	endfunction

	assign prep_x = prep_axis(smp_x_q, center_x_q, low_x_q, high_x_q, dead_zone_q);
	assign prep_y = prep_axis(smp_y_q, center_y_q, low_y_q, high_y_q, dead_zone_q);

	jc_div u_div_x (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (cmd.load),
		.step     (cmd.step),
		.dividend (prep_x.num_mag),
		.divisor  (prep_x.span_mag),
		.quotient (quo_x)
	);

	jc_div u_div_y (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (cmd.load),
		.step     (cmd.step),
		.dividend (prep_y.num_mag),
		.divisor  (prep_y.span_mag),
		.quotient (quo_y)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			center_x_q  <= SW'(512);
			low_x_q     <= '0;
			high_x_q    <= SW'(1023);
			center_y_q  <= SW'(512);
			low_y_q     <= '0;
			high_y_q    <= SW'(1023);
			dead_zone_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				jc_pkg::REG_CENTER_X: center_x_q  <= cfg_data;
				jc_pkg::REG_LOW_X:    low_x_q     <= cfg_data;
				jc_pkg::REG_HIGH_X:   high_x_q    <= cfg_data;
				jc_pkg::REG_CENTER_Y: center_y_q  <= cfg_data;
				jc_pkg::REG_LOW_Y:    low_y_q     <= cfg_data;
				jc_pkg::REG_HIGH_Y:   high_y_q    <= cfg_data;
				jc_pkg::REG_DEAD:     dead_zone_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			smp_x_q <= sample_x;
			smp_y_q <= sample_y;
			level_q <= button_level;
		end
		if (cmd.load) begin
			neg_x_q  <= prep_x.neg;
			zero_x_q <= prep_x.zero;
			neg_y_q  <= prep_y.neg;
			zero_y_q <= prep_y.zero;
		end
		if (cmd.commit) begin
			pos_x_q <= neg_x ? -$signed({1'b0, sat_x}) : $signed({1'b0, sat_x});
			pos_y_q <= neg_y ? -$signed({1'b0, sat_y}) : $signed({1'b0, sat_y});
		end
	end

	// Saturated magnitudes; a zero span forces the axis to zero.
	always_comb begin
		sat_x = (|quo_x[jc_pkg::DIV_W-1:MW]) ? MW'(jc_pkg::POS_MAX) : quo_x[MW-1:0];
		sat_y = (|quo_y[jc_pkg::DIV_W-1:MW]) ? MW'(jc_pkg::POS_MAX) : quo_y[MW-1:0];
		if (zero_x_q) sat_x = '0;
		if (zero_y_q) sat_y = '0;
		neg_x  = neg_x_q && (sat_x != '0);
		neg_y  = neg_y_q && (sat_y != '0);
		ax_ext = {1'b0, sat_x};
		ay_ext = {1'b0, sat_y};
	end

	// Stick event machine.
	always_comb begin
		stick_d = stick_q;
		if (ax_ext < (MW+1)'(jc_pkg::ZERO_LIMIT) && ay_ext < (MW+1)'(jc_pkg::ZERO_LIMIT)) begin
			stick_d = jc_pkg::STICK_ZERO;
		end else begin
			if (stick_d inside {[jc_pkg::STICK_MV_RIGHT:jc_pkg::STICK_MV_DOWN]}) begin
				stick_d = stick_d - 4'd4;
			end else if (stick_d > jc_pkg::STICK_MV_DOWN) begin
				stick_d = jc_pkg::STICK_ZERO;
			end
			if (ax_ext > ay_ext + (MW+1)'(jc_pkg::DOMINANCE_MARGIN)) begin
				if (!neg_x && ax_ext > (MW+1)'(jc_pkg::MOVE_LIMIT)
				    && stick_d != jc_pkg::STICK_RIGHT) begin
					stick_d = jc_pkg::STICK_MV_RIGHT;
				end else if (neg_x && ax_ext > (MW+1)'(jc_pkg::MOVE_LIMIT)
				             && stick_d != jc_pkg::STICK_LEFT) begin
					stick_d = jc_pkg::STICK_MV_LEFT;
				end
			end else if (ay_ext > ax_ext + (MW+1)'(jc_pkg::DOMINANCE_MARGIN)) begin
				if (!neg_y && ay_ext > (MW+1)'(jc_pkg::MOVE_LIMIT)
				    && stick_d != jc_pkg::STICK_UP) begin
					stick_d = jc_pkg::STICK_MV_UP;
				end else if (neg_y && ay_ext > (MW+1)'(jc_pkg::MOVE_LIMIT)
				             && stick_d != jc_pkg::STICK_DOWN) begin
					stick_d = jc_pkg::STICK_MV_DOWN;
				end
			end
		end
	end

	// Button event machine; events last one item before settling.
	always_comb begin
		button_d = button_q;
		if (button_d == jc_pkg::BTN_PRESSED) begin
			button_d = jc_pkg::BTN_HELD;
		end else if (button_d == jc_pkg::BTN_RELEASED) begin
			button_d = jc_pkg::BTN_IDLE;
		end
		if (!level_q) begin
			if (button_d != jc_pkg::BTN_HELD) button_d = jc_pkg::BTN_PRESSED;
		end else if (button_d != jc_pkg::BTN_IDLE) begin
			button_d = jc_pkg::BTN_RELEASED;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stick_q  <= jc_pkg::STICK_ZERO;
			button_q <= jc_pkg::BTN_IDLE;
		end else if (cmd.commit) begin
			stick_q  <= stick_d;
			button_q <= button_d;
		end
	end

	assign pos_x       = pos_x_q;
	assign pos_y       = pos_y_q;
	assign stick_code  = stick_q;
	assign button_code = button_q;

endmodule

// ----- design/jc_ctrl.sv -----
// ----------------------------------------------------------------------------
// jc_ctrl: joystick conditioner controller
// Sequences capture, operand preparation, divider steps and the commit of
// one item into the output register, and owns the handshakes.
// ----------------------------------------------------------------------------
module jc_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	output logic            out_valid,
	input  logic            out_ready,
	output jc_pkg::jc_cmd_t cmd
);

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_PREP = 2'd1;
	localparam logic [1:0] S_DIV  = 2'd2;
	localparam logic [1:0] S_DONE = 2'd3;

	logic [1:0]               state_q;
	logic [jc_pkg::CNT_W-1:0] cnt_q;
	logic                     out_valid_q;
	logic                     commit;

	assign in_ready = (state_q == S_IDLE);
	// The output register is free when empty or being drained this cycle.
	assign commit   = (state_q == S_DONE) && (!out_valid_q || out_ready);

	assign cmd.capture = in_valid && in_ready;
	assign cmd.load    = (state_q == S_PREP);
	assign cmd.step    = (state_q == S_DIV);
	assign cmd.commit  = commit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (commit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_valid) state_q <= S_PREP;
				end
				S_PREP: begin
					cnt_q   <= jc_pkg::CNT_W'(jc_pkg::DIV_STEPS - 1);
					state_q <= S_DIV;
				end
				S_DIV: begin
					cnt_q <= cnt_q - 1'b1;
					if (cnt_q == '0) state_q <= S_DONE;
				end
				S_DONE: begin
					if (commit) state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign out_valid = out_valid_q;

	a_accept_starts: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> (state_q == S_PREP))
		else $error("accepted item did not start preparation");

	a_div_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DIV && cnt_q == '0) |=> (state_q == S_DONE))
		else $error("divider did not finish after its last step");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DONE && out_valid_q && !out_ready) |=> (state_q == S_DONE && out_valid_q))
		else $error("waiting result was overwritten");

	a_prep_loads: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_PREP) |=> (state_q == S_DIV && cnt_q == jc_pkg::CNT_W'(jc_pkg::DIV_STEPS - 1)))
		else $error("divider sequence not started after preparation");

endmodule

// ----- design/joystick_conditioner.sv -----
// ----------------------------------------------------------------------------
// joystick_conditioner: two-axis joystick calibration and event decoding
//
// Channel  Handshake             Payload
// in       in_valid / in_ready   sample_x, sample_y, button_level
// out      out_valid / out_ready pos_x, pos_y, stick_code, button_code
// cfg      cfg_we (no wait)      cfg_index, cfg_data
//
// Each item goes through capture, operand preparation, 17 divider
// steps (one quotient bit per cycle in the two per-axis shift-subtract
// dividers), and commit into the output register.
// A new item is accepted while the previous result waits in the output
// register; commit stalls only while that register is still full.
// Reset restores the calibration defaults and sets both event machines idle.
// ----------------------------------------------------------------------------
module joystick_conditioner (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [jc_pkg::INDEX_W-1:0]      cfg_index,
	input  logic [jc_pkg::SAMPLE_W-1:0]     cfg_data,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic [jc_pkg::SAMPLE_W-1:0]     sample_x,
	input  logic [jc_pkg::SAMPLE_W-1:0]     sample_y,
	input  logic                            button_level,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic signed [jc_pkg::POS_W-1:0] pos_x,
	output logic signed [jc_pkg::POS_W-1:0] pos_y,
	output logic [jc_pkg::STICK_W-1:0]      stick_code,
	output logic [jc_pkg::BUTTON_W-1:0]     button_code
);

	jc_pkg::jc_cmd_t cmd;

	jc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.cmd       (cmd)
	);

	jc_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.sample_x     (sample_x),
		.sample_y     (sample_y),
		.button_level (button_level),
		.pos_x        (pos_x),
		.pos_y        (pos_y),
		.stick_code   (stick_code),
		.button_code  (button_code)
	);

endmodule

// ----- dv/joystick_conditioner_tb.sv -----
// ----------------------------------------------------------------------------
// joystick_conditioner_tb: self-checking testbench of the joystick conditioner
// Feeds sample items through the valid/ready input with bursty timing, stalls
// the result channel on its own pattern, and checks every result field
// against a predictor of the axis scaling and the stick and button machines.
// Calibration is reprogrammed between phases while the block is idle.
// ----------------------------------------------------------------------------
module joystick_conditioner_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CLK_PERIOD      = 8;
	localparam int RESET_CYCLES    = 7;
	localparam int RANDOM_PHASES   = 8;
	localparam int ITEMS_PER_PHASE = 175;
	localparam int QUIET_LIMIT     = 2000;
	localparam int DRAIN_CYCLES    = 40;
	localparam int SAMPLE_MAX      = 1023;
	localparam int NUM_REGS        = 7;

	typedef struct packed {
		logic [jc_pkg::SAMPLE_W-1:0] sx;
		logic [jc_pkg::SAMPLE_W-1:0] sy;
		logic                        level;
	} stick_sample_t;

	typedef struct packed {
		logic signed [jc_pkg::POS_W-1:0] px;
		logic signed [jc_pkg::POS_W-1:0] py;
		logic [jc_pkg::STICK_W-1:0]      stick;
		logic [jc_pkg::BUTTON_W-1:0]     button;
	} joy_report_t;

	logic                            clk          = 1'b0;
	logic                            arst_n       = 1'b0;
	logic                            cfg_we       = 1'b0;
	logic [jc_pkg::INDEX_W-1:0]      cfg_index    = '0;
	logic [jc_pkg::SAMPLE_W-1:0]     cfg_data     = '0;
	logic                            in_valid     = 1'b0;
	logic                            in_ready;
	logic [jc_pkg::SAMPLE_W-1:0]     sample_x     = '0;
	logic [jc_pkg::SAMPLE_W-1:0]     sample_y     = '0;
	logic                            button_level = 1'b1;
	logic                            out_valid;
	logic                            out_ready    = 1'b0;
	logic signed [jc_pkg::POS_W-1:0] pos_x;
	logic signed [jc_pkg::POS_W-1:0] pos_y;
	logic [jc_pkg::STICK_W-1:0]      stick_code;
	logic [jc_pkg::BUTTON_W-1:0]     button_code;

	stick_sample_t pending_samples[$];
	joy_report_t   expected_reports[$];

	// Shadow of the calibration registers and of the two event machines.
	logic [jc_pkg::SAMPLE_W-1:0] cal [NUM_REGS];
	logic [jc_pkg::STICK_W-1:0]  stick_state;
	logic [jc_pkg::BUTTON_W-1:0] button_state;

	logic        in_fire_q = 1'b0;
	int unsigned fail_count;
	int unsigned item_count;
	int unsigned cal_count;
	int unsigned move_events;
	int unsigned saturated;
	int unsigned presses;
	int unsigned quiet_cycles;

	joystick_conditioner u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.sample_x     (sample_x),
		.sample_y     (sample_y),
		.button_level (button_level),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.pos_x        (pos_x),
		.pos_y        (pos_y),
		.stick_code   (stick_code),
		.button_code  (button_code)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	function automatic int scale_percent(input logic [jc_pkg::SAMPLE_W-1:0] sample,
			input logic [jc_pkg::SAMPLE_W-1:0] center,
			input logic [jc_pkg::SAMPLE_W-1:0] lo,
			input logic [jc_pkg::SAMPLE_W-1:0] hi);
		int off;
		int num;
		int span;
		int num_mag;
		int span_mag;
		int quo;
		off = int'(sample) - int'(center);
		if ((off < 0 ? -off : off) < int'(cal[jc_pkg::REG_DEAD]))
			off = 0;
		num = off * jc_pkg::PERCENT;
		span = (num < 0) ? int'(center) - int'(lo) : int'(hi) - int'(center);
		if (span == 0)
			return 0;
		num_mag  = num < 0 ? -num : num;
		span_mag = span < 0 ? -span : span;
		quo = num_mag / span_mag;
		if (quo > jc_pkg::POS_MAX)
			quo = jc_pkg::POS_MAX;
		return ((num < 0) != (span < 0)) ? -quo : quo;
	endfunction

	// Computes the result of one item and advances both event machines.
	function automatic joy_report_t predict_report(input stick_sample_t s);
		int          px;
		int          py;
		int          ax;
		int          ay;
		logic [jc_pkg::STICK_W-1:0]  st;
		logic [jc_pkg::BUTTON_W-1:0] bt;
		joy_report_t r;
		px = scale_percent(s.sx, cal[jc_pkg::REG_CENTER_X], cal[jc_pkg::REG_LOW_X],
			cal[jc_pkg::REG_HIGH_X]);
		py = scale_percent(s.sy, cal[jc_pkg::REG_CENTER_Y], cal[jc_pkg::REG_LOW_Y],
			cal[jc_pkg::REG_HIGH_Y]);
		ax = px < 0 ? -px : px;
		ay = py < 0 ? -py : py;

		st = stick_state;
		if (ax < jc_pkg::ZERO_LIMIT && ay < jc_pkg::ZERO_LIMIT) begin
			st = jc_pkg::STICK_ZERO;
		end else begin
			// A one-shot move event falls back to its held direction first.
			case (st)
				jc_pkg::STICK_MV_RIGHT: st = jc_pkg::STICK_RIGHT;
				jc_pkg::STICK_MV_LEFT:  st = jc_pkg::STICK_LEFT;
				jc_pkg::STICK_MV_UP:    st = jc_pkg::STICK_UP;
				jc_pkg::STICK_MV_DOWN:  st = jc_pkg::STICK_DOWN;
				jc_pkg::STICK_ZERO, jc_pkg::STICK_RIGHT, jc_pkg::STICK_LEFT,
				jc_pkg::STICK_UP, jc_pkg::STICK_DOWN: ;
				default:                st = jc_pkg::STICK_ZERO;
			endcase
			if (ax > ay + jc_pkg::DOMINANCE_MARGIN) begin
				if (px > jc_pkg::MOVE_LIMIT && st != jc_pkg::STICK_RIGHT)
					st = jc_pkg::STICK_MV_RIGHT;
				else if (px < -jc_pkg::MOVE_LIMIT && st != jc_pkg::STICK_LEFT)
					st = jc_pkg::STICK_MV_LEFT;
			end else if (ay > ax + jc_pkg::DOMINANCE_MARGIN) begin
				if (py > jc_pkg::MOVE_LIMIT && st != jc_pkg::STICK_UP)
					st = jc_pkg::STICK_MV_UP;
				else if (py < -jc_pkg::MOVE_LIMIT && st != jc_pkg::STICK_DOWN)
					st = jc_pkg::STICK_MV_DOWN;
			end
		end
		stick_state = st;

		bt = button_state;
		if (bt == jc_pkg::BTN_PRESSED)
			bt = jc_pkg::BTN_HELD;
		else if (bt == jc_pkg::BTN_RELEASED)
			bt = jc_pkg::BTN_IDLE;
		if (!s.level) begin
			if (bt != jc_pkg::BTN_HELD)
				bt = jc_pkg::BTN_PRESSED;
		end else if (bt != jc_pkg::BTN_IDLE) begin
			bt = jc_pkg::BTN_RELEASED;
		end
		button_state = bt;

		r.px     = px[jc_pkg::POS_W-1:0];
		r.py     = py[jc_pkg::POS_W-1:0];
		r.stick  = st;
		r.button = bt;
		return r;
	endfunction

	function automatic int clamp_sample(input int v);
		return (v < 0) ? 0 : (v > SAMPLE_MAX) ? SAMPLE_MAX : v;
	endfunction

	// Sender: bursts of items separated by random gaps.
	int unsigned burst_left = 1;
	int unsigned gap_left   = 0;
	always @(negedge clk) begin
		stick_sample_t nxt;
		if (arst_n) begin
			if (in_valid && !in_fire_q) begin
				// Item still waiting for acceptance: hold it.
			end else if (gap_left > 0) begin
				in_valid <= 1'b0;
				gap_left--;
			end else if (pending_samples.size() > 0) begin
				nxt = pending_samples.pop_front();
				in_valid     <= 1'b1;
				sample_x     <= nxt.sx;
				sample_y     <= nxt.sy;
				button_level <= nxt.level;
				burst_left--;
				if (burst_left == 0) begin
					burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 150)
						: $urandom_range(1, 24);
					gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 40);
				end
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// Receiver: runs of ready separated by stalls, with occasional long clear runs.
	int unsigned ready_left = 0;
	int unsigned stall_left = 0;
	always @(negedge clk) begin
		if (ready_left > 0) begin
			out_ready <= 1'b1;
			ready_left--;
		end else if (stall_left > 0) begin
			out_ready <= 1'b0;
			stall_left--;
		end else begin
			out_ready <= 1'b1;
			ready_left = ($urandom_range(0, 9) == 0) ? $urandom_range(200, 400)
				: $urandom_range(1, 40);
			stall_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 48);
		end
	end

	// Prediction on input acceptance, comparison on result acceptance.
	always @(posedge clk) begin
		stick_sample_t seen;
		joy_report_t   want;
		if (!arst_n) begin
			in_fire_q <= 1'b0;
		end else begin
			in_fire_q <= in_valid && in_ready;
			if (in_valid && in_ready) begin
				seen.sx    = sample_x;
				seen.sy    = sample_y;
				seen.level = button_level;
				expected_reports.push_back(predict_report(seen));
				item_count++;
			end
			if (out_valid && out_ready) begin
				if (expected_reports.size() == 0) begin
					$error("result with no item outstanding: pos_x %0d pos_y %0d stick %0d button %0d",
						pos_x, pos_y, stick_code, button_code);
					fail_count++;
				end else begin
					want = expected_reports.pop_front();
					if (pos_x !== want.px) begin
						$error("pos_x mismatch: expected %0d, actual %0d", want.px, pos_x);
						fail_count++;
					end
					if (pos_y !== want.py) begin
						$error("pos_y mismatch: expected %0d, actual %0d", want.py, pos_y);
						fail_count++;
					end
					if (stick_code !== want.stick) begin
						$error("stick_code mismatch: expected %0d, actual %0d",
							want.stick, stick_code);
						fail_count++;
					end
					if (button_code !== want.button) begin
						$error("button_code mismatch: expected %0d, actual %0d",
							want.button, button_code);
						fail_count++;
					end
					if (want.stick >= jc_pkg::STICK_MV_RIGHT)
						move_events++;
					if (want.px == jc_pkg::POS_MAX || want.px == -jc_pkg::POS_MAX
							|| want.py == jc_pkg::POS_MAX || want.py == -jc_pkg::POS_MAX)
						saturated++;
					if (want.button == jc_pkg::BTN_PRESSED)
						presses++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_we)
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("joystick_conditioner test failed");
				$finish;
			end
		end
	end

	task automatic add_item(input int sx, input int sy, input logic level);
		stick_sample_t s;
		s.sx    = sx[jc_pkg::SAMPLE_W-1:0];
		s.sy    = sy[jc_pkg::SAMPLE_W-1:0];
		s.level = level;
		pending_samples.push_back(s);
	endtask

	// Returns at a falling edge with no item queued, in flight or owed. The
	// check runs at rising edges, where the sender's queue and valid are settled.
	task automatic wait_idle();
		@(posedge clk);
		while (pending_samples.size() != 0 || in_valid || expected_reports.size() != 0)
			@(posedge clk);
		@(negedge clk);
	endtask

	task automatic load_calibration(input int cx, input int lx, input int hx,
			input int cy, input int ly, input int hy, input int dz);
		int vals [NUM_REGS];
		logic [jc_pkg::INDEX_W-1:0] regs [NUM_REGS];
		wait_idle();
		vals = '{cx, lx, hx, cy, ly, hy, dz};
		regs = '{jc_pkg::REG_CENTER_X, jc_pkg::REG_LOW_X, jc_pkg::REG_HIGH_X,
			jc_pkg::REG_CENTER_Y, jc_pkg::REG_LOW_Y, jc_pkg::REG_HIGH_Y, jc_pkg::REG_DEAD};
		for (int i = 0; i < NUM_REGS; i++) begin
			cfg_we    <= 1'b1;
			cfg_index <= regs[i];
			cfg_data  <= vals[i][jc_pkg::SAMPLE_W-1:0];
			cal[regs[i]] = vals[i][jc_pkg::SAMPLE_W-1:0];
			@(negedge clk);
		end
		cfg_we <= 1'b0;
		cal_count++;
	endtask

	initial begin
		int          kind;
		int          count;
		int          dir;
		int          amp;
		int          amp2;
		int          hold;
		int          dx;
		int          dy;
		int          btn_run;
		logic        lvl;
		cal[jc_pkg::REG_CENTER_X] = 10'd512;
		cal[jc_pkg::REG_LOW_X]    = 10'd0;
		cal[jc_pkg::REG_HIGH_X]   = 10'd1023;
		cal[jc_pkg::REG_CENTER_Y] = 10'd512;
		cal[jc_pkg::REG_LOW_Y]    = 10'd0;
		cal[jc_pkg::REG_HIGH_Y]   = 10'd1023;
		cal[jc_pkg::REG_DEAD]     = 10'd0;
		stick_state  = jc_pkg::STICK_ZERO;
		button_state = jc_pkg::BTN_IDLE;
		fail_count   = 0;
		item_count   = 0;
		cal_count    = 1;
		move_events  = 0;
		saturated    = 0;
		presses      = 0;
		quiet_cycles = 0;
		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Reset calibration: each direction moved then held, every button phase.
		add_item(512, 512, 1'b1);
		add_item(1023, 512, 1'b1);
		add_item(1023, 512, 1'b1);
		add_item(0, 512, 1'b0);
		add_item(0, 512, 1'b0);
		add_item(512, 1023, 1'b1);
		add_item(512, 1023, 1'b1);
		add_item(512, 0, 1'b0);
		add_item(512, 0, 1'b1);
		add_item(600, 600, 1'b0);
		add_item(512, 512, 1'b1);

		// Narrow x span saturates, zero x span on the positive side, and a
		// y calibration whose low side lies above its center.
		load_calibration(500, 490, 500, 100, 200, 1023, 0);
		add_item(0, 100, 1'b1);
		add_item(1023, 0, 1'b1);
		add_item(505, 1023, 1'b0);
		add_item(495, 50, 1'b0);
		add_item(500, 100, 1'b1);

		// Widest dead zone: only a full-scale offset gets through it.
		load_calibration(0, 0, 1023, 1023, 0, 1023, 1023);
		add_item(1022, 0, 1'b1);
		add_item(1023, 1022, 1'b0);
		add_item(0, 1023, 1'b1);

		lvl = 1'b1;
		btn_run = 0;
		for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
			kind = (phase == 0) ? 0 : $urandom_range(0, 9);
			if (kind < 6)
				load_calibration($urandom_range(400, 624), $urandom_range(0, 120),
					$urandom_range(900, 1023), $urandom_range(400, 624),
					$urandom_range(0, 120), $urandom_range(900, 1023),
					$urandom_range(0, 40));
			else if (kind < 8)
				load_calibration($urandom_range(0, 1023), $urandom_range(0, 1023),
					$urandom_range(0, 1023), $urandom_range(0, 1023),
					$urandom_range(0, 1023), $urandom_range(0, 1023),
					$urandom_range(0, 1023));
			else
				load_calibration($urandom_range(0, 1) * SAMPLE_MAX,
					$urandom_range(0, 1) * SAMPLE_MAX, $urandom_range(0, 1) * SAMPLE_MAX,
					$urandom_range(0, 1) * SAMPLE_MAX, $urandom_range(0, 1) * SAMPLE_MAX,
					$urandom_range(0, 1) * SAMPLE_MAX, $urandom_range(0, 1) * SAMPLE_MAX);

			count = 0;
			while (count < ITEMS_PER_PHASE) begin
				if ($urandom_range(0, 4) == 0) begin
					add_item($urandom_range(0, 1023), $urandom_range(0, 1023),
						1'($urandom_range(0, 1)));
					count++;
				end else begin
					// A gesture: the stick is pushed one way and held a few items.
					dir  = $urandom_range(0, 5);
					amp  = $urandom_range(0, 560);
					amp2 = $urandom_range(0, 560);
					hold = $urandom_range(1, 6);
					repeat (hold) begin
						dx = int'($urandom_range(0, 16)) - 8;
						dy = int'($urandom_range(0, 16)) - 8;
						case (dir)
							1: dx = amp;
							2: dx = -amp;
							3: dy = amp;
							4: dy = -amp;
							5: begin
								dx = $urandom_range(0, 1) ? amp : -amp;
								dy = $urandom_range(0, 1) ? amp2 : -amp2;
							end
							default: ;
						endcase
						if (btn_run == 0) begin
							lvl = ~lvl;
							btn_run = $urandom_range(1, 6);
						end
						btn_run--;
						add_item(clamp_sample(int'(cal[jc_pkg::REG_CENTER_X]) + dx),
							clamp_sample(int'(cal[jc_pkg::REG_CENTER_Y]) + dy), lvl);
						count++;
					end
				end
			end
		end

		wait_idle();
		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("Checked %0d items under %0d calibrations.", item_count, cal_count);
		$display("Seen %0d stick move events, %0d saturated results, %0d button presses.",
			move_events, saturated, presses);
		if (fail_count == 0 && expected_reports.size() == 0) begin
			$display("joystick_conditioner test passed");
		end else begin
			$display("joystick_conditioner test failed");
		end
		$finish;
	end

endmodule
